// ===== rtl/stns_pkg.sv =====
`default_nettype none
package stns_pkg;

    localparam int SineDepth = 256;
    localparam int LogDepth  = 256;

    // Register addresses (byte address / 4)
    localparam logic [2:0] REG_SAMPLE_COUNT = 3'd0;
    localparam logic [2:0] REG_START_INC    = 3'd1;
    localparam logic [2:0] REG_INC_SLOPE    = 3'd2;
    localparam logic [2:0] REG_TIME_STEP    = 3'd3;
    localparam logic [2:0] REG_TONE_VOL     = 3'd4;
    localparam logic [2:0] REG_NOISE_VOL    = 3'd5;
    localparam logic [2:0] REG_DECAY        = 3'd6;

    localparam logic [14:0] OUT_SCALE = 15'd19660;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = 64'd0;
        b = 64'd1 << 62;
        while (b > v)
        begin
            b = b >> 2;
        end
        while (b != 64'd0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] sine_entry(input int k);
        logic [63:0] x;
        logic [63:0] term;
        longint s;
        x = (64'd1686629713 * 64'(k)) / 64'(SineDepth);
        term = x;
        s = longint'(x);
        for (int n = 1; n <= 8; n++)
        begin
            term = ((((term * x) >> 30) * x) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1)
            begin
                s = s - longint'(term);
            end
            else
            begin
                s = s + longint'(term);
            end
        end
        if (s < 0)
        begin
            s = 0;
        end
        if (s > (longint'(1) << 30))
        begin
            s = longint'(1) << 30;
        end
        return 16'(((64'(s) * 64'd32768) + (64'd1 << 29)) >> 30);
    endfunction

    function automatic logic [15:0] log_entry(input int k);
        logic [63:0] m;
        logic [15:0] res;
        m = (64'd1 << 30) + ((64'(k) << 30) / 64'(LogDepth));
        res = 16'd0;
        for (int i = 1; i <= 16; i++)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31))
            begin
                m = m >> 1;
                res[16 - i] = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic logic [16:0] exp_entry(input int k);
        logic [63:0] roots [1:16];
        logic [63:0] r;
        logic [63:0] acc;
        logic [63:0] x;
        r = 64'd1 << 29;
        for (int i = 1; i <= 16; i++)
        begin
            r = isqrt64(r << 30);
            roots[i] = r;
        end
        acc = 64'd1 << 30;
        x = (64'(k) << 16) / 64'(LogDepth);
        for (int i = 1; i <= 16; i++)
        begin
            if (x[16 - i])
            begin
                acc = (acc * roots[i]) >> 30;
            end
        end
        return 17'((acc + (64'd1 << 13)) >> 14);
    endfunction

    typedef logic [15:0] sine_tab_t [SineDepth + 1];
    typedef logic [15:0] log_tab_t [LogDepth];
    typedef logic [16:0] exp_tab_t [LogDepth];

    function automatic sine_tab_t build_sine();
        sine_tab_t t;
        for (int k = 0; k <= SineDepth; k++)
        begin
            t[k] = sine_entry(k);
        end
        return t;
    endfunction

    function automatic log_tab_t build_log();
        log_tab_t t;
        for (int k = 0; k < LogDepth; k++)
        begin
            t[k] = log_entry(k);
        end
        return t;
    endfunction

    function automatic exp_tab_t build_exp();
        exp_tab_t t;
        for (int k = 0; k < LogDepth; k++)
        begin
            t[k] = exp_entry(k);
        end
        return t;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine();
    localparam log_tab_t  LOG_TAB  = build_log();
    localparam exp_tab_t  EXP_TAB  = build_exp();

endpackage
`default_nettype wire

// ===== rtl/swept_tone_noise_synth.sv =====
`default_nettype none
// Channel   | Handshake              | Payload
// ----------+------------------------+--------------------------------------
// input     | in_valid / in_ready    | restart, noise_word
// output    | out_valid / out_ready  | sample_value, last_sample, idle
// config    | APB psel/penable/pwrite| paddr[4:0], pwdata, prdata, pready
//
// When an effect runs, one input transaction goes through accept, phase
// advance, then a sequencer steps one shared 32x32 multiplier through tone,
// noise, envelope power, envelope-weighted magnitude and the output scale
// (low and high half), and a last step loads the output register.
// Idle ticks skip the multiplier. in_ready is high only while the sequencer waits
// for input; a finished sample holds in the last step until the output register
// is free or being drained. rst_n clears voice state and restores config defaults.
module swept_tone_noise_synth (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        restart,
    input  wire logic [15:0] noise_word,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic signed [15:0] sample_value,
    output logic             last_sample,
    output logic             idle,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PREP  = 4'd1;
    localparam logic [3:0] S_TONE  = 4'd2;
    localparam logic [3:0] S_NOISE = 4'd3;
    localparam logic [3:0] S_ENVLG = 4'd4;
    localparam logic [3:0] S_ENVEX = 4'd5;
    localparam logic [3:0] S_MAG1  = 4'd6;
    localparam logic [3:0] S_MAG2  = 4'd7;
    localparam logic [3:0] S_MAG3  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    localparam logic [2:0] REG_SAMPLE_COUNT_L = stns_pkg::REG_SAMPLE_COUNT;
    localparam logic [2:0] REG_START_INC_L    = stns_pkg::REG_START_INC;
    localparam logic [2:0] REG_INC_SLOPE_L    = stns_pkg::REG_INC_SLOPE;
    localparam logic [2:0] REG_TIME_STEP_L    = stns_pkg::REG_TIME_STEP;
    localparam logic [2:0] REG_TONE_VOL_L     = stns_pkg::REG_TONE_VOL;
    localparam logic [2:0] REG_NOISE_VOL_L    = stns_pkg::REG_NOISE_VOL;
    localparam logic [2:0] REG_DECAY_L        = stns_pkg::REG_DECAY;

    // configuration
    logic [15:0] sample_count_reg;
    logic [30:0] start_inc_reg;
    logic [20:0] inc_slope_reg;
    logic [24:0] time_step_reg;
    logic [8:0]  tone_vol_reg;
    logic [8:0]  noise_vol_reg;
    logic [6:0]  decay_reg;

    // voice state
    logic [15:0] sample_index_reg;
    logic [31:0] phase_acc_reg;
    logic [31:0] phase_step_reg;
    logic [24:0] time_acc_reg;
    logic        running_reg;

    logic [3:0]  state_reg;
    logic [15:0] noise_reg;
    logic signed [26:0] sum_reg;
    logic [16:0] env_reg;
    logic [63:0] prod_reg;
    logic [46:0] lo_reg;
    logic        last_reg;

    logic        out_valid_reg;
    logic [15:0] out_value_reg;
    logic        out_last_reg;
    logic        out_idle_reg;

    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_comb
    begin
        case (cfg_idx)
            REG_SAMPLE_COUNT_L: prdata = {16'd0, sample_count_reg};
            REG_START_INC_L:    prdata = {1'b0, start_inc_reg};
            REG_INC_SLOPE_L:    prdata = {11'd0, inc_slope_reg};
            REG_TIME_STEP_L:    prdata = {7'd0, time_step_reg};
            REG_TONE_VOL_L:     prdata = {23'd0, tone_vol_reg};
            REG_NOISE_VOL_L:    prdata = {23'd0, noise_vol_reg};
            REG_DECAY_L:        prdata = {25'd0, decay_reg};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= 16'd1024;
            start_inc_reg    <= 31'd0;
            inc_slope_reg    <= 21'd0;
            time_step_reg    <= 25'd16384;
            tone_vol_reg     <= 9'd0;
            noise_vol_reg    <= 9'd0;
            decay_reg        <= 7'd16;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_SAMPLE_COUNT_L: sample_count_reg <= pwdata[15:0];
                REG_START_INC_L:    start_inc_reg    <= pwdata[30:0];
                REG_INC_SLOPE_L:    inc_slope_reg    <= pwdata[20:0];
                REG_TIME_STEP_L:    time_step_reg    <= pwdata[24:0];
                REG_TONE_VOL_L:     tone_vol_reg     <= pwdata[8:0];
                REG_NOISE_VOL_L:    noise_vol_reg    <= pwdata[8:0];
                REG_DECAY_L:        decay_reg        <= pwdata[6:0];
                default:            ;
            endcase
        end
    end

    // sine lookup from phase (32-bit phase, 257-entry quarter table)
    logic [1:0]  quad;
    logic [7:0]  qpos;
    logic [8:0]  sidx;
    logic [15:0] sine_mag;
    assign quad = phase_acc_reg[31:30];
    assign qpos = phase_acc_reg[29:22];
    assign sidx = quad[0] ? (9'd256 - {1'b0, qpos}) : {1'b0, qpos};
    assign sine_mag = stns_pkg::SINE_TAB[sidx];

    // envelope log stage: u = 2^24 - t, leading one search, log lookup
    logic [24:0] u_val;
    logic [4:0]  lead;
    logic [7:0]  lidx;
    logic [24:0] u_frac;
    logic [20:0] neg_log;
    always_comb
    begin
        u_val = 25'h1000000 - time_acc_reg;
        lead = 5'd0;
        for (int b = 1; b < 25; b++)
        begin
            if (u_val[b])
            begin
                lead = 5'(b);
            end
        end
        u_frac = u_val & ~(25'd1 << lead);
        // top 8 bits below the leading one
        lidx = 8'(({8'd0, u_frac} << 8) >> lead);
        neg_log = 21'({16'd0, 5'(5'd24 - lead)} << 16) - 21'(stns_pkg::LOG_TAB[lidx]);
    end

    // shared multiplier
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic signed [16:0] noise_s;
    logic [26:0] sum_mag;
    assign noise_s = $signed({1'b0, noise_reg}) - 17'sd32768;
    assign sum_mag = sum_reg[26] ? 27'(-sum_reg) : 27'(sum_reg);

    always_comb
    begin
        case (state_reg)
            S_TONE:
            begin
                mul_a = {16'd0, sine_mag};
                mul_b = {23'd0, tone_vol_reg};
            end
            S_NOISE:
            begin
                mul_a = 32'(noise_s[16] ? 17'(-noise_s) : 17'(noise_s));
                mul_b = {23'd0, noise_vol_reg};
            end
            S_ENVLG:
            begin
                mul_a = {11'd0, neg_log};
                mul_b = {25'd0, decay_reg};
            end
            S_MAG1:
            begin
                mul_a = {5'd0, sum_mag};
                mul_b = {15'd0, env_reg};
            end
            S_MAG2:
            begin
                // low 32 bits of the weighted magnitude
                mul_a = prod_reg[31:0];
                mul_b = {17'd0, stns_pkg::OUT_SCALE};
            end
            S_MAG3:
            begin
                // high bits of the weighted magnitude
                mul_a = {22'd0, prod_reg[41:32]};
                mul_b = {17'd0, stns_pkg::OUT_SCALE};
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    // exp stage from y = prod_reg >> 4
    logic [27:0] y_val;
    logic [16:0] env_val;
    assign y_val = 28'(prod_reg >> 4);
    always_comb
    begin
        if (time_acc_reg[24] || y_val[27:16] >= 12'd17)
        begin
            env_val = 17'd0;
        end
        else
        begin
            env_val = stns_pkg::EXP_TAB[y_val[15:8]] >> y_val[20:16];
        end
    end

    logic [15:0] val_sat;
    assign val_sat = (prod_reg[63:39] > 25'd32767) ? 16'd32767 : 16'(prod_reg >> 39);

    logic        take_in;
    logic        out_free;
    logic        out_load;
    logic [25:0] nt;
    logic [32:0] slope_ext;
    assign out_free = !out_valid_reg || out_ready;
    assign out_load = out_free && ((state_reg == S_PREP && !running_reg) ||
                                   state_reg == S_DONE);
    assign in_ready = (state_reg == S_IDLE);
    assign take_in  = in_valid && in_ready;
    assign nt = {1'b0, time_acc_reg} + {1'b0, time_step_reg};
    assign slope_ext = 33'($signed(inc_slope_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            sample_index_reg <= 16'd0;
            phase_acc_reg    <= 32'd0;
            phase_step_reg   <= 32'd0;
            time_acc_reg     <= 25'd0;
            running_reg      <= 1'b0;
            noise_reg        <= 16'd0;
            sum_reg          <= 27'sd0;
            env_reg          <= 17'd0;
            prod_reg         <= 64'd0;
            lo_reg           <= 47'd0;
            last_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_value_reg    <= 16'd0;
            out_last_reg     <= 1'b0;
            out_idle_reg     <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (take_in)
                    begin
                        noise_reg <= noise_word;
                        if (restart)
                        begin
                            running_reg      <= 1'b1;
                            sample_index_reg <= 16'd0;
                            phase_acc_reg    <= 32'd0;
                            time_acc_reg     <= 25'd0;
                            phase_step_reg   <= {1'b0, start_inc_reg};
                        end
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    if (!running_reg)
                    begin
                        if (out_free)
                        begin
                            out_valid_reg <= 1'b1;
                            out_value_reg <= 16'd0;
                            out_last_reg  <= 1'b0;
                            out_idle_reg  <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                    end
                    else
                    begin
                        // advance phase before the table lookup
                        phase_acc_reg <= phase_acc_reg + phase_step_reg;
                        last_reg <= ((sample_index_reg + 16'd1) == sample_count_reg);
                        state_reg <= S_TONE;
                    end
                end
                S_TONE:
                begin
                    sum_reg   <= quad[1] ? -$signed(27'(mul_p)) : $signed(27'(mul_p));
                    state_reg <= S_NOISE;
                end
                S_NOISE:
                begin
                    sum_reg   <= noise_s[16] ? sum_reg - $signed(27'(mul_p))
                                             : sum_reg + $signed(27'(mul_p));
                    state_reg <= S_ENVLG;
                end
                S_ENVLG:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_ENVEX;
                end
                S_ENVEX:
                begin
                    env_reg   <= env_val;
                    state_reg <= S_MAG1;
                end
                S_MAG1:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_MAG2;
                end
                S_MAG2:
                begin
                    lo_reg    <= mul_p[46:0];
                    state_reg <= S_MAG3;
                end
                S_MAG3:
                begin
                    prod_reg  <= (mul_p << 32) + {17'd0, lo_reg};
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_value_reg <= sum_reg[26] ? 16'(-val_sat) : val_sat;
                        out_last_reg  <= last_reg;
                        out_idle_reg  <= 1'b0;
                        phase_step_reg <= phase_step_reg + slope_ext[31:0];
                        time_acc_reg  <= (nt > 26'h1000000) ? 25'h1000000 : nt[24:0];
                        sample_index_reg <= sample_index_reg + 16'd1;
                        if (last_reg)
                        begin
                            running_reg <= 1'b0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_value = out_value_reg;
    assign last_sample  = out_last_reg;
    assign idle         = out_idle_reg;

endmodule
`default_nettype wire
